@@ design/mwo_pkg.sv @@
// Package for the mecanum wheel odometry block: field widths, fixed constants,
// register codes, the config and multiplier control structs and the sequencer states.
// Depends on nothing; every other file of the block imports it.
package mwo_pkg;

  localparam int STAMP_W    = 30;
  localparam int TICK_IN_W  = 32;
  localparam int CFG_W      = 16;
  localparam int VEL_W      = 32;
  localparam int LIMB_W     = 32;
  localparam int QUO_W      = 31;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int BASE_W     = STAMP_W + 2 * CFG_W;
  localparam int DEN_W      = BASE_W + CFG_W;

  localparam int DEN_V_SHIFT     = 9;
  localparam int YAW_EXTRA_SHIFT = 7;

  localparam logic [STAMP_W-1:0] NSEC_WRAP      = 30'd1000000000;
  localparam logic [LIMB_W-1:0]  HALF_TWO_PI_E9 = 32'd3141592654;

  localparam logic [VEL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [VEL_W-1:0] SAT_NEG = 32'h8000_0000;

  localparam logic [CFG_W-1:0] COUNTS_PER_REV_RST    = 16'd42;
  localparam logic [CFG_W-1:0] GEAR_RATIO_Q8_RST     = 16'd1280;
  localparam logic [CFG_W-1:0] WHEEL_RADIUS_Q16_RST  = 16'd4588;
  localparam logic [CFG_W-1:0] HALF_BASE_SUM_Q16_RST = 16'd24183;

  typedef enum logic [1:0] {
    REG_COUNTS_PER_REV,
    REG_GEAR_RATIO_Q8,
    REG_WHEEL_RADIUS_Q16,
    REG_HALF_BASE_SUM_Q16
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] counts_per_rev;
    logic [CFG_W-1:0] gear_ratio_q8;
    logic [CFG_W-1:0] wheel_radius_q16;
    logic [CFG_W-1:0] half_base_sum_q16;
  } mwo_cfg_t;

  typedef struct packed {
    logic load;
    logic step;
  } mul_ctrl_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_YAW
  } axis_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DEN_N,
    ST_DEN_G,
    ST_BASE,
    ST_DEN_H,
    ST_DEN_Y,
    ST_LOAD,
    ST_NUM_R,
    ST_NUM_K,
    ST_DIV_GO,
    ST_DIV,
    ST_DONE
  } seq_state_t;

endpackage

@@ design/mwo_in_if.sv @@
// Input channel of the odometry block: one beat is one encoder sample.
// Depends on mwo_pkg for the field widths.
interface mwo_in_if import mwo_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [STAMP_W-1:0]          stamp_nsec;
  logic signed [TICK_IN_W-1:0] ticks_front_left;
  logic signed [TICK_IN_W-1:0] ticks_front_right;
  logic signed [TICK_IN_W-1:0] ticks_rear_left;
  logic signed [TICK_IN_W-1:0] ticks_rear_right;

  modport source (
    output valid, stamp_nsec, ticks_front_left, ticks_front_right,
           ticks_rear_left, ticks_rear_right,
    input  ready
  );

  modport sink (
    input  valid, stamp_nsec, ticks_front_left, ticks_front_right,
           ticks_rear_left, ticks_rear_right,
    output ready
  );
endinterface

@@ design/mwo_out_if.sv @@
// Output channel of the odometry block: one beat is one velocity estimate.
// Depends on mwo_pkg for the field widths.
interface mwo_out_if import mwo_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] yaw_rate;
  logic                    zero_interval;

  modport source (
    output valid, vel_x, vel_y, yaw_rate, zero_interval,
    input  ready
  );

  modport sink (
    input  valid, vel_x, vel_y, yaw_rate, zero_interval,
    output ready
  );
endinterface

@@ design/mwo_cfg_regs.sv @@
// APB-style configuration registers of the odometry block (four 16-bit registers).
// Depends on mwo_pkg for register codes, reset values and the configuration struct.
module mwo_cfg_regs import mwo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output mwo_cfg_t              cfg
);

  cfg_reg_t sel;
  logic     wr;

  assign sel    = cfg_reg_t'(paddr[APB_ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.counts_per_rev    <= COUNTS_PER_REV_RST;
      cfg.gear_ratio_q8     <= GEAR_RATIO_Q8_RST;
      cfg.wheel_radius_q16  <= WHEEL_RADIUS_Q16_RST;
      cfg.half_base_sum_q16 <= HALF_BASE_SUM_Q16_RST;
    end else if (wr) begin
      unique case (sel)
        REG_COUNTS_PER_REV:    cfg.counts_per_rev    <= pwdata[CFG_W-1:0];
        REG_GEAR_RATIO_Q8:     cfg.gear_ratio_q8     <= pwdata[CFG_W-1:0];
        REG_WHEEL_RADIUS_Q16:  cfg.wheel_radius_q16  <= pwdata[CFG_W-1:0];
        REG_HALF_BASE_SUM_Q16: cfg.half_base_sum_q16 <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_COUNTS_PER_REV:    prdata = APB_DATA_W'(cfg.counts_per_rev);
      REG_GEAR_RATIO_Q8:     prdata = APB_DATA_W'(cfg.gear_ratio_q8);
      REG_WHEEL_RADIUS_Q16:  prdata = APB_DATA_W'(cfg.wheel_radius_q16);
      REG_HALF_BASE_SUM_Q16: prdata = APB_DATA_W'(cfg.half_base_sum_q16);
    endcase
  end

endmodule

@@ design/mwo_limb_mul.sv @@
// Shared wide-by-32-bit multiplier: one 32x32 multiply-add, one limb, per stepped cycle.
// The working word rotates right by a limb each step. Depends on mwo_pkg.
module mwo_limb_mul import mwo_pkg::*; #(
  parameter int NLIMB = 3
) (
  input  logic                      clk,
  input  mul_ctrl_t                 ctrl,
  input  logic [NLIMB*LIMB_W-1:0]   load_val,
  input  logic [LIMB_W-1:0]         scalar,
  output logic [NLIMB*LIMB_W-1:0]   work
);

  localparam int WORK_W = NLIMB * LIMB_W;

  logic [LIMB_W-1:0]   carry;
  logic [2*LIMB_W-1:0] prod;

  assign prod = {{LIMB_W{1'b0}}, work[LIMB_W-1:0]} * {{LIMB_W{1'b0}}, scalar}
              + {{LIMB_W{1'b0}}, carry};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work  <= load_val;
      carry <= '0;
    end else if (ctrl.step) begin
      work  <= {prod[LIMB_W-1:0], work[WORK_W-1:LIMB_W]};
      carry <= prod[2*LIMB_W-1:LIMB_W];
    end
  end

endmodule

@@ design/mwo_div.sv @@
// Restoring divider, one quotient bit per cycle, with a saturation check first.
// Gives a 31-bit magnitude and a flag when the quotient reaches 2^31. Depends on mwo_pkg.
module mwo_div import mwo_pkg::*; #(
  parameter int NUM_W = 105
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic             sat,
  output logic [QUO_W-1:0] quo
);

  localparam int DSH_W = DEN_W + QUO_W;
  localparam int CMP_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             last;
  logic [NUM_W-1:0] rem;
  logic [DSH_W-1:0] dsh;
  logic [CMP_W-1:0] rem_x;
  logic [CMP_W-1:0] dsh_x;
  logic [CMP_W-1:0] diff;
  logic             ge;

  assign rem_x = CMP_W'(rem);
  assign dsh_x = CMP_W'(dsh);
  assign diff  = rem_x - dsh_x;
  assign ge    = rem_x >= dsh_x;
  assign last  = cnt == CNT_W'(QUO_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= {den, QUO_W'(0)};
    end else if (busy) begin
      dsh <= dsh >> 1;
      if (cnt == '0) begin
        sat <= ge;
      end else begin
        quo <= {quo[QUO_W-2:0], ge};
        if (ge) begin
          rem <= NUM_W'(diff);
        end
      end
    end
  end

endmodule

@@ design/mecanum_wheel_odometry_top.sv @@
// Mecanum wheel odometry: velocities and yaw rate from successive encoder samples.
// The first sample after reset is stored and gives no beat. A zero time interval
// gives a beat with zero velocities and the zero-interval flag set. Otherwise the
// velocities come from the 32x32 limb multiplier and the divider, run once per axis.
// Synchronous reset clears the sequencer, the output beat and the stored-sample flag.
module mecanum_wheel_odometry_top import mwo_pkg::*; #(
  parameter int TICK_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  mwo_in_if.sink                samples,
  mwo_out_if.source             odometry
);

  localparam int SUM_W    = TICK_WIDTH + 3;
  localparam int MAG_W    = TICK_WIDTH + 2;
  localparam int PROD_W   = MAG_W + CFG_W + LIMB_W;
  localparam int NUM_W    = PROD_W + FRAC_BITS + YAW_EXTRA_SHIFT;
  localparam int WORK_MIN = (PROD_W > DEN_W) ? PROD_W : DEN_W;
  localparam int NLIMB    = (WORK_MIN + LIMB_W - 1) / LIMB_W;
  localparam int WORK_W   = NLIMB * LIMB_W;
  localparam int LC_W     = $clog2(NLIMB);

  mwo_cfg_t   cfg;
  seq_state_t state;
  seq_state_t state_next;
  axis_t      axis;

  logic in_acc;
  logic in_ready;
  logic have_prev;

  logic [STAMP_W-1:0] stamp_red;
  logic [STAMP_W-1:0] dt_calc;
  logic [STAMP_W-1:0] prev_stamp;
  logic [STAMP_W-1:0] dt_reg;

  logic signed [TICK_WIDTH-1:0] cur [4];
  logic signed [TICK_WIDTH-1:0] prev_ticks [4];
  logic signed [TICK_WIDTH-1:0] delta [4];
  logic signed [SUM_W-1:0]      sum [3];
  logic signed [SUM_W-1:0]      sum_sel;
  logic                         neg_sel;
  logic [MAG_W-1:0]             mag_sel;

  logic [CFG_W-1:0] n_eff;
  logic [CFG_W-1:0] g_eff;
  logic [CFG_W-1:0] h_eff;

  mul_ctrl_t          mul_ctrl;
  logic [WORK_W-1:0]  load_val;
  logic [LIMB_W-1:0]  scalar;
  logic [WORK_W-1:0]  work;
  logic [LC_W-1:0]    limb_cnt;
  logic               limb_last;

  logic [BASE_W-1:0] base_reg;
  logic [DEN_W-1:0]  den_y;
  logic [DEN_W-1:0]  den_sel;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  num_sel;

  logic             div_start;
  logic             div_done;
  logic             div_sat;
  logic [QUO_W-1:0] quo;
  logic [VEL_W-1:0] quo_ext;
  logic [VEL_W-1:0] res_val;

  logic [VEL_W-1:0] res [3];
  logic             zflag;

  logic             out_valid;
  logic [VEL_W-1:0] out_vel_x;
  logic [VEL_W-1:0] out_vel_y;
  logic [VEL_W-1:0] out_yaw;
  logic             out_zero;

  mwo_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mwo_limb_mul #(
    .NLIMB (NLIMB)
  ) u_mul (
    .clk      (clk),
    .ctrl     (mul_ctrl),
    .load_val (load_val),
    .scalar   (scalar),
    .work     (work)
  );

  mwo_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_sel),
    .den   (den_sel),
    .done  (div_done),
    .sat   (div_sat),
    .quo   (quo)
  );

  // Sample front end: stamp folding, time delta and wrapped tick deltas.
  assign in_acc = samples.valid & in_ready;
  assign samples.ready = in_ready;

  assign stamp_red = (samples.stamp_nsec >= NSEC_WRAP) ? samples.stamp_nsec - NSEC_WRAP
                                                       : samples.stamp_nsec;
  assign dt_calc   = (stamp_red >= prev_stamp) ? stamp_red - prev_stamp
                                               : stamp_red + NSEC_WRAP - prev_stamp;

  assign cur[0] = TICK_WIDTH'(samples.ticks_front_left);
  assign cur[1] = TICK_WIDTH'(samples.ticks_front_right);
  assign cur[2] = TICK_WIDTH'(samples.ticks_rear_left);
  assign cur[3] = TICK_WIDTH'(samples.ticks_rear_right);

  assign n_eff = (cfg.counts_per_rev == '0) ? CFG_W'(1) : cfg.counts_per_rev;
  assign g_eff = (cfg.gear_ratio_q8 == '0) ? CFG_W'(1) : cfg.gear_ratio_q8;
  assign h_eff = (cfg.half_base_sum_q16 == '0) ? CFG_W'(1) : cfg.half_base_sum_q16;

  assign sum_sel = sum[axis];
  assign neg_sel = sum_sel[SUM_W-1];
  assign mag_sel = MAG_W'(neg_sel ? -sum_sel : sum_sel);

  assign limb_last = limb_cnt == LC_W'(NLIMB - 1);

  assign prod    = work[PROD_W-1:0];
  assign num_sel = (axis == AXIS_YAW) ? NUM_W'(prod) << (FRAC_BITS + YAW_EXTRA_SHIFT)
                                      : NUM_W'(prod) << FRAC_BITS;
  assign den_sel = (axis == AXIS_YAW) ? den_y : DEN_W'(base_reg) << DEN_V_SHIFT;

  assign quo_ext = VEL_W'(quo);
  assign res_val = div_sat ? (neg_sel ? SAT_NEG : SAT_POS)
                           : (neg_sel ? VEL_W'(-quo_ext) : quo_ext);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_acc && have_prev) state_next = ST_PREP;
      ST_PREP:   state_next = (dt_reg == '0) ? ST_DONE : ST_DEN_N;
      ST_DEN_N:  if (limb_last) state_next = ST_DEN_G;
      ST_DEN_G:  if (limb_last) state_next = ST_BASE;
      ST_BASE:   state_next = ST_DEN_H;
      ST_DEN_H:  if (limb_last) state_next = ST_DEN_Y;
      ST_DEN_Y:  state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_NUM_R;
      ST_NUM_R:  if (limb_last) state_next = ST_NUM_K;
      ST_NUM_K:  if (limb_last) state_next = ST_DIV_GO;
      ST_DIV_GO: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = (axis == AXIS_YAW) ? ST_DONE : ST_LOAD;
        end
      end
      ST_DONE:   if (!out_valid || odometry.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mul_ctrl  = '0;
    load_val  = WORK_W'(mag_sel);
    scalar    = HALF_TWO_PI_E9;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_PREP: begin
        mul_ctrl.load = 1'b1;
        load_val      = WORK_W'(dt_reg);
      end
      ST_DEN_N: begin
        mul_ctrl.step = 1'b1;
        scalar        = LIMB_W'(n_eff);
      end
      ST_DEN_G: begin
        mul_ctrl.step = 1'b1;
        scalar        = LIMB_W'(g_eff);
      end
      ST_DEN_H: begin
        mul_ctrl.step = 1'b1;
        scalar        = LIMB_W'(h_eff);
      end
      ST_LOAD: mul_ctrl.load = 1'b1;
      ST_NUM_R: begin
        mul_ctrl.step = 1'b1;
        scalar        = LIMB_W'(cfg.wheel_radius_q16);
      end
      ST_NUM_K:  mul_ctrl.step = 1'b1;
      ST_DIV_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= AXIS_X;
      have_prev <= 1'b0;
      limb_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        have_prev <= 1'b1;
      end
      if (mul_ctrl.step) begin
        limb_cnt <= limb_last ? '0 : limb_cnt + 1'b1;
      end
      if (state == ST_PREP) begin
        axis <= AXIS_X;
      end else if (state == ST_DIV && div_done && axis != AXIS_YAW) begin
        axis <= (axis == AXIS_X) ? AXIS_Y : AXIS_YAW;
      end
      if (state == ST_DONE && (!out_valid || odometry.ready)) begin
        out_valid <= 1'b1;
      end else if (odometry.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      prev_stamp <= stamp_red;
      dt_reg     <= dt_calc;
      for (int i = 0; i < 4; i++) begin
        prev_ticks[i] <= cur[i];
        delta[i]      <= cur[i] - prev_ticks[i];
      end
    end
    if (state == ST_PREP) begin
      sum[AXIS_X]   <= SUM_W'(delta[0]) + SUM_W'(delta[1])
                     + SUM_W'(delta[2]) + SUM_W'(delta[3]);
      sum[AXIS_Y]   <= SUM_W'(delta[1]) + SUM_W'(delta[2])
                     - SUM_W'(delta[0]) - SUM_W'(delta[3]);
      sum[AXIS_YAW] <= SUM_W'(delta[1]) + SUM_W'(delta[3])
                     - SUM_W'(delta[0]) - SUM_W'(delta[2]);
      zflag         <= dt_reg == '0;
      for (int a = 0; a < 3; a++) begin
        res[a] <= '0;
      end
    end
    if (state == ST_BASE) begin
      base_reg <= work[BASE_W-1:0];
    end
    if (state == ST_DEN_Y) begin
      den_y <= work[DEN_W-1:0];
    end
    if (state == ST_DIV && div_done) begin
      res[axis] <= res_val;
    end
    if (state == ST_DONE && (!out_valid || odometry.ready)) begin
      out_vel_x <= res[AXIS_X];
      out_vel_y <= res[AXIS_Y];
      out_yaw   <= res[AXIS_YAW];
      out_zero  <= zflag;
    end
  end

  assign odometry.valid         = out_valid;
  assign odometry.vel_x         = out_vel_x;
  assign odometry.vel_y         = out_vel_y;
  assign odometry.yaw_rate      = out_yaw;
  assign odometry.zero_interval = out_zero;

endmodule

@@ sim/mwo_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the mecanum wheel odometry block: follows the register port and the
// sample channel, predicts every velocity beat and compares it with the output channel.
// Depends on mwo_pkg and on the mwo_in_if and mwo_out_if channel interfaces.
module mwo_checker import mwo_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  mwo_in_if                     samples,
  mwo_out_if                    odometry,
  output int                    errors,
  output int                    outstanding
);

  typedef struct packed {
    logic [VEL_W-1:0] vel_x;
    logic [VEL_W-1:0] vel_y;
    logic [VEL_W-1:0] yaw_rate;
    logic             zero_interval;
  } motion_t;

  mwo_cfg_t             cfg;
  logic [STAMP_W-1:0]   last_stamp;
  logic [TICK_IN_W-1:0] last_ticks [4];
  logic                 seen_first;
  motion_t              motion_q [$];
  motion_t              oldest;
  int                   mismatches = 0;

  function automatic logic [CFG_W-1:0] at_least_one(input logic [CFG_W-1:0] value);
    return (value == '0) ? CFG_W'(1) : value;
  endfunction

  // Exact quotient on the magnitude, truncated toward zero, saturated at 2^31.
  function automatic logic [VEL_W-1:0] scale_axis(input logic signed [63:0] total,
                                                  input logic [127:0] den,
                                                  input int shift,
                                                  input logic [CFG_W-1:0] radius);
    logic [127:0] num;
    logic [127:0] quo;
    logic         neg;
    neg = total < 0;
    num = neg ? 128'(-total) : 128'(total);
    num = (num * radius * HALF_TWO_PI_E9) << shift;
    if (num >= (den << QUO_W)) begin
      return neg ? SAT_NEG : SAT_POS;
    end
    quo = num / den;
    return neg ? VEL_W'(-quo) : VEL_W'(quo);
  endfunction

  task automatic absorb_sample();
    logic [STAMP_W-1:0]          stamp;
    logic [STAMP_W-1:0]          dt;
    logic [TICK_IN_W-1:0]        now_ticks [4];
    logic signed [TICK_IN_W-1:0] delta;
    logic signed [63:0]          wheel [4];
    logic [127:0]                base;
    logic [127:0]                den_v;
    logic [127:0]                den_y;
    motion_t                     motion;
    int                          i;
    stamp = samples.stamp_nsec;
    if (stamp >= NSEC_WRAP) begin
      stamp = stamp - NSEC_WRAP;
    end
    now_ticks[0] = samples.ticks_front_left;
    now_ticks[1] = samples.ticks_front_right;
    now_ticks[2] = samples.ticks_rear_left;
    now_ticks[3] = samples.ticks_rear_right;
    if (!seen_first) begin
      seen_first = 1'b1;
      last_stamp = stamp;
      last_ticks = now_ticks;
      return;
    end
    dt = (stamp >= last_stamp) ? stamp - last_stamp : stamp + NSEC_WRAP - last_stamp;
    for (i = 0; i < 4; i++) begin
      delta = now_ticks[i] - last_ticks[i];
      wheel[i] = delta;
    end
    last_stamp = stamp;
    last_ticks = now_ticks;
    motion = '0;
    if (dt == '0) begin
      motion.zero_interval = 1'b1;
    end else begin
      base = 128'(dt) * at_least_one(cfg.counts_per_rev) * at_least_one(cfg.gear_ratio_q8);
      den_v = base << DEN_V_SHIFT;
      den_y = base * at_least_one(cfg.half_base_sum_q16);
      motion.vel_x = scale_axis(wheel[0] + wheel[1] + wheel[2] + wheel[3], den_v,
                                FRAC_BITS, cfg.wheel_radius_q16);
      motion.vel_y = scale_axis(-wheel[0] + wheel[1] + wheel[2] - wheel[3], den_v,
                                FRAC_BITS, cfg.wheel_radius_q16);
      motion.yaw_rate = scale_axis(-wheel[0] + wheel[1] - wheel[2] + wheel[3], den_y,
                                   FRAC_BITS + YAW_EXTRA_SHIFT, cfg.wheel_radius_q16);
    end
    motion_q.push_back(motion);
  endtask

  task automatic compare_field(input string label, input logic [VEL_W-1:0] want,
                               input logic [VEL_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg = '{COUNTS_PER_REV_RST, GEAR_RATIO_Q8_RST, WHEEL_RADIUS_Q16_RST,
              HALF_BASE_SUM_Q16_RST};
      last_stamp = '0;
      last_ticks = '{default: '0};
      seen_first = 1'b0;
      motion_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[APB_ADDR_W-1:2]))
          REG_COUNTS_PER_REV:    cfg.counts_per_rev    = pwdata[CFG_W-1:0];
          REG_GEAR_RATIO_Q8:     cfg.gear_ratio_q8     = pwdata[CFG_W-1:0];
          REG_WHEEL_RADIUS_Q16:  cfg.wheel_radius_q16  = pwdata[CFG_W-1:0];
          REG_HALF_BASE_SUM_Q16: cfg.half_base_sum_q16 = pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
      if (samples.valid && samples.ready) begin
        absorb_sample();
      end
      if (odometry.valid && odometry.ready) begin
        if (motion_q.size() == 0) begin
          mismatches++;
          $display("%0t: beat %h %h %h %b arrived with nothing expected", $time,
                   odometry.vel_x, odometry.vel_y, odometry.yaw_rate,
                   odometry.zero_interval);
        end else begin
          oldest = motion_q.pop_front();
          compare_field("vel_x", oldest.vel_x, odometry.vel_x);
          compare_field("vel_y", oldest.vel_y, odometry.vel_y);
          compare_field("yaw_rate", oldest.yaw_rate, odometry.yaw_rate);
          compare_field("zero_interval", VEL_W'(oldest.zero_interval),
                        VEL_W'(odometry.zero_interval));
        end
      end
    end
    errors <= mismatches;
    outstanding <= motion_q.size();
  end

endmodule

@@ sim/mecanum_wheel_odometry_top_tb.sv @@
`timescale 1ns / 100ps
// Top of the odometry testbench: clock, reset, register writes and encoder samples,
// with random gaps and stalls on both channels; the verdict comes from mwo_checker.
// Depends on mwo_pkg, the channel interfaces, mwo_checker and the block itself.
module mecanum_wheel_odometry_top_tb;
  import mwo_pkg::*;

  localparam int FRAC_BITS        = 16;
  localparam int TICK_WIDTH       = 32;
  localparam int PHASES           = 9;
  localparam int RANDOM_PER_PHASE = 144;
  localparam int SETTLE_CYCLES    = 150;
  localparam int SQUEEZE_CYCLES   = 3000;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  calm;
  logic                  squeeze;
  int                    errors;
  int                    outstanding;

  logic [STAMP_W-1:0]    clock_stamp;
  logic [TICK_IN_W-1:0]  odo_ticks [4];

  mwo_in_if  samples_if ();
  mwo_out_if odometry_if ();

  mecanum_wheel_odometry_top #(
    .TICK_WIDTH(TICK_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .samples (samples_if),
    .odometry(odometry_if)
  );

  mwo_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .samples    (samples_if),
    .odometry   (odometry_if),
    .errors     (errors),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic write_register(input cfg_reg_t which, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {which, 2'b00};
    pwdata  <= {16'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic offer_sample(input logic [STAMP_W-1:0] stamp,
                              input logic [TICK_IN_W-1:0] fl, input logic [TICK_IN_W-1:0] fr,
                              input logic [TICK_IN_W-1:0] rl, input logic [TICK_IN_W-1:0] rr);
    if (!calm) begin
      while ($urandom_range(99) < 32) begin
        samples_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    samples_if.valid             <= 1'b1;
    samples_if.stamp_nsec        <= stamp;
    samples_if.ticks_front_left  <= fl;
    samples_if.ticks_front_right <= fr;
    samples_if.ticks_rear_left   <= rl;
    samples_if.ticks_rear_right  <= rr;
    do @(posedge clk); while (!samples_if.ready);
    clock_stamp = (stamp >= NSEC_WRAP) ? stamp - NSEC_WRAP : stamp;
    odo_ticks = '{fl, fr, rl, rr};
  endtask

  // Mostly a wheel set that keeps turning with small steps; the rest is jumps,
  // zero intervals, out-of-range stamps and unrelated noise.
  task automatic offer_random_sample();
    int unsigned          next_stamp;
    int                   span;
    int                   pick;
    int                   k;
    logic [TICK_IN_W-1:0] ticks [4];
    pick = $urandom_range(99);
    if (pick < 8) begin
      next_stamp = clock_stamp;
    end else if (pick < 16) begin
      next_stamp = clock_stamp + $urandom_range(999_999_999, 1);
    end else if (pick < 24) begin
      next_stamp = clock_stamp + $urandom_range(50, 1);
    end else begin
      next_stamp = clock_stamp + $urandom_range(3_000_000, 1);
    end
    if (next_stamp >= NSEC_WRAP) begin
      next_stamp -= NSEC_WRAP;
    end
    span = (pick % 4 == 0) ? (1 << 20) : 4000;
    for (k = 0; k < 4; k++) begin
      ticks[k] = odo_ticks[k] + ($urandom_range(2 * span) - span);
    end
    if (pick >= 90) begin
      for (k = 0; k < 4; k++) begin
        ticks[k] = $urandom();
      end
      next_stamp = $urandom_range(2 ** STAMP_W - 1);
    end else if (pick >= 84) begin
      next_stamp = NSEC_WRAP + $urandom_range(2 ** STAMP_W - 1 - NSEC_WRAP);
    end else if (pick >= 80) begin
      for (k = 0; k < 4; k++) begin
        ticks[k] = 32'h7FFF_F000 + $urandom_range(8191);
      end
    end
    offer_sample(STAMP_W'(next_stamp), ticks[0], ticks[1], ticks[2], ticks[3]);
  endtask

  task automatic settle();
    samples_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    bit squeezed;
    squeezed = 1'b0;
    odometry_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        odometry_if.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else begin
        odometry_if.ready <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] setup [4];
    int               phase;
    int               n;
    int               k;
    rst                          <= 1'b1;
    psel                         <= 1'b0;
    penable                      <= 1'b0;
    pwrite                       <= 1'b0;
    paddr                        <= '0;
    pwdata                       <= '0;
    calm                         <= 1'b0;
    squeeze                      <= 1'b0;
    samples_if.valid             <= 1'b0;
    samples_if.stamp_nsec        <= '0;
    samples_if.ticks_front_left  <= '0;
    samples_if.ticks_front_right <= '0;
    samples_if.ticks_rear_left   <= '0;
    samples_if.ticks_rear_right  <= '0;
    clock_stamp = '0;
    odo_ticks = '{default: '0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer_sample(30'd0, 0, 0, 0, 0);
    offer_sample(30'd1_000_000, 100, 100, 100, 100);
    offer_sample(30'd2_000_000, 0, 200, 200, 0);
    offer_sample(30'd3_000_000, -100, 300, 100, 100);
    offer_sample(30'd3_000_000, 5, 5, 5, 5);
    offer_sample(30'd999_999_999, 5, 5, 5, 5);
    offer_sample(30'd0, 10, -10, 10, -10);
    offer_sample(30'h3FFF_FFFF, 10, -10, 10, -10);
    offer_sample(30'd73_741_823, 0, 0, 0, 0);
    offer_sample(30'd73_741_824, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    offer_sample(30'd73_741_825, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    offer_sample(30'd73_741_826, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    offer_sample(30'd1_000_000_000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF);
    offer_sample(30'd1, -1, -1, -1, -1);
    offer_sample(30'd500_000, 1000, 2000, -3000, 4000);
    settle();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: setup = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        1: setup = '{16'd1, 16'd256, 16'd1, 16'd1};
        2: setup = '{16'd0, 16'd0, 16'hFFFF, 16'd0};
        3: setup = '{16'd1, 16'd256, 16'hFFFF, 16'd1};
        4: setup = '{16'd0, 16'd0, 16'd0, 16'd0};
        8: setup = '{COUNTS_PER_REV_RST, GEAR_RATIO_Q8_RST, WHEEL_RADIUS_Q16_RST,
                     HALF_BASE_SUM_Q16_RST};
        default: setup = '{16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 256)),
                           16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1))};
      endcase
      for (k = 0; k < 4; k++) begin
        write_register(cfg_reg_t'(k), setup[k]);
      end
      calm <= (phase == 7);
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (phase == 5 && n == 40) begin
          squeeze <= 1'b1;
        end
        offer_random_sample();
      end
      settle();
    end

    if (errors == 0) begin
      $display("mecanum_wheel_odometry_top_tb OK");
    end else begin
      $display("mecanum_wheel_odometry_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("mecanum_wheel_odometry_top_tb NOT OK");
    $finish;
  end

endmodule

@@ mecanum_wheel_odometry_top.f @@
design/mwo_pkg.sv
design/mwo_in_if.sv
design/mwo_out_if.sv
design/mwo_cfg_regs.sv
design/mwo_limb_mul.sv
design/mwo_div.sv
design/mecanum_wheel_odometry_top.sv
sim/mwo_checker.sv
sim/mecanum_wheel_odometry_top_tb.sv
